[design/ridct_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the reduced IDCT row/column pass.
// Used by ridct_csr and reduced_idct_row_col_pass; no dependencies.
package ridct_pkg;

   localparam int WW      = 12;   // butterfly weight width
   localparam int CW      = 16;   // coefficient width
   localparam int VW      = 16;   // output element width
   localparam int NV      = 8;    // output elements per item
   localparam int REQ_DW  = 136;  // 131 payload bits padded to bytes
   localparam int RSP_DW  = NV * VW;
   localparam int CSR_AW  = 3;

   typedef logic [WW-1:0] weight_type;

   typedef struct packed {
      weight_type w1;
      weight_type w2;
      weight_type w3;
      weight_type w5;
      weight_type w6;
      weight_type w7;
   } weights_type;

endpackage

[design/reduced_idct_row_col_pass.sv]
`timescale 1ns / 1ps
// Reduced-coefficient 8-point integer IDCT pass, row or column mode.
// Each item passes through seven register stages, each with its own valid bit;
// throughput is one item per cycle while rsp_tready does not stall the pipeline.
// Items with a zero count or the reserved mode are dropped at stage 0.
// Reset clears all valid bits and loads the default butterfly weights.
// Depends on ridct_pkg and ridct_csr.
module reduced_idct_row_col_pass (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [2:0] nonzero_count, [18:3] c0, [34:19] c1, [50:35] c2, [66:51] c3,
   // [98:67] pred_low, [130:99] pred_high, [135:131] zero
   input  logic [ridct_pkg::REQ_DW-1:0]   req_tdata,
   // [1:0] mode
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [15:0] v0, [31:16] v1, ... [127:112] v7
   output logic [ridct_pkg::RSP_DW-1:0]   rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ridct_pkg::CSR_AW-1:0]   csr_index,
   input  logic [ridct_pkg::WW-1:0]       csr_data
);
   import ridct_pkg::*;

   localparam int NS = 7;
   localparam int XW = 28;   // x0
   localparam int PW = 30;   // weight products
   localparam int EW = 31;   // even/odd sums
   localparam int SW = 32;   // d5 +/- d8
   localparam int MW = 41;   // 181 * sum
   localparam int RW = 32;   // rotated terms
   localparam int YW = 33;   // butterfly outputs
   localparam int HW = 20;   // shifted outputs

   localparam logic [1:0] MODE_COL   = 2'd0;
   localparam logic [1:0] MODE_INTER = 2'd1;
   localparam logic [1:0] MODE_INTRA = 2'd2;

   localparam logic signed [XW-1:0] ROW_BIAS = 28'sd8192;
   localparam logic signed [XW-1:0] COL_BIAS = 28'sd128;
   localparam logic signed [PW-1:0] PRD_RND  = 30'sd4;
   localparam logic signed [MW-1:0] ROT_MUL  = 41'sd181;
   localparam logic signed [MW-1:0] ROT_RND  = 41'sd128;
   localparam logic signed [HW:0]   PIX_MAX  = 21'sd255;

   typedef struct packed {
      logic        row;
      logic        inter;
      logic [63:0] pred;
   } ctl_type;

   weights_type wts;

   ridct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .weights   (wts)
   );

   // handshake and valid chain
   logic [NS-1:0] vld_ff;
   logic [NS:0]   adv;
   logic          in_ok;
   ctl_type       ctl_ff [NS-1];
   ctl_type       ctl_in;

   always_comb begin
      adv[NS] = rsp_tready;
      for (int k = NS - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = vld_ff[NS-1];

   assign in_ok = req_tvalid && (req_tdata[2:0] != 3'd0) &&
                  (req_tuser == MODE_COL || req_tuser == MODE_INTER ||
                   req_tuser == MODE_INTRA);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= in_ok;
         end
         for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign ctl_in = '{row:   req_tuser != MODE_COL,
                     inter: req_tuser == MODE_INTER,
                     pred:  req_tdata[130:67]};

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         ctl_ff[0] <= ctl_in;
      end
      for (int k = 1; k < NS - 1; k++) begin
         if (adv[k]) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   // stage 0: count masking, x0
   logic [2:0]             cnt;
   logic signed [CW-1:0]   c0, c1, c2, c3;
   logic signed [XW-1:0]   c0x;
   logic signed [XW-1:0]   s0_x0_ff, s0_x0_in;
   logic signed [CW-1:0]   s0_c1_ff, s0_c2_ff, s0_c3_ff;

   assign cnt = req_tdata[2:0];
   assign c0  = $signed(req_tdata[18:3]);
   assign c1  = $signed(req_tdata[34:19]);
   assign c2  = $signed(req_tdata[50:35]);
   assign c3  = $signed(req_tdata[66:51]);
   assign c0x = XW'(c0);
   assign s0_x0_in = (req_tuser != MODE_COL) ? (c0x <<< 8) + ROW_BIAS
                                             : (c0x <<< 11) + COL_BIAS;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s0_x0_ff <= s0_x0_in;
         s0_c1_ff <= (cnt >= 3'd2) ? c1 : '0;
         s0_c2_ff <= (cnt >= 3'd3) ? c2 : '0;
         s0_c3_ff <= (cnt >= 3'd4) ? c3 : '0;
      end
   end

   // stage 1: weight products
   logic signed [WW:0]    w1s, w2s, w3s, w5s, w6s, w7s;
   logic signed [PW-1:0]  s1_m1_ff, s1_m2_ff, s1_m3_ff, s1_m5_ff, s1_m6_ff, s1_m7_ff;
   logic signed [PW-1:0]  m1_in, m2_in, m3_in, m5_in, m6_in, m7_in;
   logic signed [XW-1:0]  s1_x0_ff;

   assign w1s = $signed({1'b0, wts.w1});
   assign w2s = $signed({1'b0, wts.w2});
   assign w3s = $signed({1'b0, wts.w3});
   assign w5s = $signed({1'b0, wts.w5});
   assign w6s = $signed({1'b0, wts.w6});
   assign w7s = $signed({1'b0, wts.w7});

   assign m1_in = PW'(w1s) * PW'(s0_c1_ff);
   assign m7_in = PW'(w7s) * PW'(s0_c1_ff);
   assign m2_in = PW'(w2s) * PW'(s0_c2_ff);
   assign m6_in = PW'(w6s) * PW'(s0_c2_ff);
   assign m3_in = PW'(w3s) * PW'(s0_c3_ff);
   assign m5_in = -(PW'(w5s) * PW'(s0_c3_ff));

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_m1_ff <= m1_in;
         s1_m2_ff <= m2_in;
         s1_m3_ff <= m3_in;
         s1_m5_ff <= m5_in;
         s1_m6_ff <= m6_in;
         s1_m7_ff <= m7_in;
         s1_x0_ff <= s0_x0_ff;
      end
   end

   // stage 2: row rounding, even part, odd sums
   logic signed [PW-1:0] p1, p2, p3, p5, p6, p7;
   logic signed [EW-1:0] s2_e0_ff, s2_e2_ff, s2_e4_ff, s2_e6_ff;
   logic signed [EW-1:0] s2_o1_ff, s2_o3_ff, s2_d5_ff, s2_d8_ff;

   assign p1 = ctl_ff[1].row ? (s1_m1_ff + PRD_RND) >>> 3 : s1_m1_ff;
   assign p2 = ctl_ff[1].row ? (s1_m2_ff + PRD_RND) >>> 3 : s1_m2_ff;
   assign p3 = ctl_ff[1].row ? (s1_m3_ff + PRD_RND) >>> 3 : s1_m3_ff;
   assign p5 = ctl_ff[1].row ? (s1_m5_ff + PRD_RND) >>> 3 : s1_m5_ff;
   assign p6 = ctl_ff[1].row ? (s1_m6_ff + PRD_RND) >>> 3 : s1_m6_ff;
   assign p7 = ctl_ff[1].row ? (s1_m7_ff + PRD_RND) >>> 3 : s1_m7_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_e0_ff <= EW'(s1_x0_ff) + EW'(p2);
         s2_e2_ff <= EW'(s1_x0_ff) - EW'(p2);
         s2_e4_ff <= EW'(s1_x0_ff) + EW'(p6);
         s2_e6_ff <= EW'(s1_x0_ff) - EW'(p6);
         s2_o1_ff <= EW'(p1) + EW'(p3);
         s2_d5_ff <= EW'(p1) - EW'(p3);
         s2_d8_ff <= EW'(p7) - EW'(p5);
         s2_o3_ff <= EW'(p5) + EW'(p7);
      end
   end

   // stage 3: rotation inputs
   logic signed [SW-1:0] s3_sp_ff, s3_sm_ff;
   logic signed [EW-1:0] s3_e0_ff, s3_e2_ff, s3_e4_ff, s3_e6_ff, s3_o1_ff, s3_o3_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_sp_ff <= SW'(s2_d5_ff) + SW'(s2_d8_ff);
         s3_sm_ff <= SW'(s2_d5_ff) - SW'(s2_d8_ff);
         s3_e0_ff <= s2_e0_ff;
         s3_e2_ff <= s2_e2_ff;
         s3_e4_ff <= s2_e4_ff;
         s3_e6_ff <= s2_e6_ff;
         s3_o1_ff <= s2_o1_ff;
         s3_o3_ff <= s2_o3_ff;
      end
   end

   // stage 4: rotation by 181/256
   logic signed [MW-1:0] q7, q5;
   logic signed [RW-1:0] s4_r7_ff, s4_r5_ff;
   logic signed [EW-1:0] s4_e0_ff, s4_e2_ff, s4_e4_ff, s4_e6_ff, s4_o1_ff, s4_o3_ff;

   assign q7 = MW'(s3_sp_ff) * ROT_MUL + ROT_RND;
   assign q5 = MW'(s3_sm_ff) * ROT_MUL + ROT_RND;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_r7_ff <= RW'(q7 >>> 8);
         s4_r5_ff <= RW'(q5 >>> 8);
         s4_e0_ff <= s3_e0_ff;
         s4_e2_ff <= s3_e2_ff;
         s4_e4_ff <= s3_e4_ff;
         s4_e6_ff <= s3_e6_ff;
         s4_o1_ff <= s3_o1_ff;
         s4_o3_ff <= s3_o3_ff;
      end
   end

   // stage 5: output butterfly and descale
   logic signed [YW-1:0] y [NV];
   logic signed [HW-1:0] s5_h_ff [NV];

   always_comb begin
      y[0] = YW'(s4_e0_ff) + YW'(s4_o1_ff);
      y[1] = YW'(s4_e4_ff) + YW'(s4_r7_ff);
      y[2] = YW'(s4_e6_ff) + YW'(s4_r5_ff);
      y[3] = YW'(s4_e2_ff) + YW'(s4_o3_ff);
      y[4] = YW'(s4_e2_ff) - YW'(s4_o3_ff);
      y[5] = YW'(s4_e6_ff) - YW'(s4_r5_ff);
      y[6] = YW'(s4_e4_ff) - YW'(s4_r7_ff);
      y[7] = YW'(s4_e0_ff) - YW'(s4_o1_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         for (int k = 0; k < NV; k++) begin
            s5_h_ff[k] <= ctl_ff[4].row ? HW'(y[k] >>> 14) : HW'(y[k] >>> 8);
         end
      end
   end

   // stage 6: prediction add (inter mode) and clip (row modes), output register
   logic signed [HW:0]   pix [NV];
   logic [VW-1:0]        v_in [NV];
   logic [VW-1:0]        s6_v_ff [NV];

   always_comb begin
      for (int k = 0; k < NV; k++) begin
         pix[k] = (HW+1)'(s5_h_ff[k]);
         if (ctl_ff[5].inter) begin
            pix[k] = pix[k] + (HW+1)'($signed({1'b0, ctl_ff[5].pred[8*k +: 8]}));
         end
         if (!ctl_ff[5].row) begin
            v_in[k] = s5_h_ff[k][VW-1:0];
         end else if (pix[k][HW]) begin
            v_in[k] = '0;
         end else if (pix[k] > PIX_MAX) begin
            v_in[k] = VW'(PIX_MAX);
         end else begin
            v_in[k] = VW'(pix[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         for (int k = 0; k < NV; k++) begin
            s6_v_ff[k] <= v_in[k];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NV; k++) begin
         rsp_tdata[VW*k +: VW] = s6_v_ff[k];
      end
   end

endmodule

[design/ridct_csr.sv]
`timescale 1ns / 1ps
// Butterfly weight registers written through the csr channel.
// Depends on ridct_pkg.
module ridct_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ridct_pkg::CSR_AW-1:0]  csr_index,
   input  logic [ridct_pkg::WW-1:0]      csr_data,
   output ridct_pkg::weights_type        weights
);
   import ridct_pkg::*;

   localparam logic [CSR_AW-1:0] CSR_W1 = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_W2 = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_W3 = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_W5 = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_W6 = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_W7 = 3'd5;

   localparam weight_type W1_RST = 12'd2841;
   localparam weight_type W2_RST = 12'd2676;
   localparam weight_type W3_RST = 12'd2408;
   localparam weight_type W5_RST = 12'd1609;
   localparam weight_type W6_RST = 12'd1108;
   localparam weight_type W7_RST = 12'd565;

   weights_type wts_ff;
   weights_type wts_in;

   assign csr_ready = 1'b1;
   assign weights   = wts_ff;

   always_comb begin
      wts_in = wts_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_W1:  wts_in.w1 = csr_data;
            CSR_W2:  wts_in.w2 = csr_data;
            CSR_W3:  wts_in.w3 = csr_data;
            CSR_W5:  wts_in.w5 = csr_data;
            CSR_W6:  wts_in.w6 = csr_data;
            CSR_W7:  wts_in.w7 = csr_data;
            default: wts_in = wts_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wts_ff <= '{w1: W1_RST, w2: W2_RST, w3: W3_RST,
                     w5: W5_RST, w6: W6_RST, w7: W7_RST};
      end else begin
         wts_ff <= wts_in;
      end
   end

endmodule
